FILE: rtl/sid_pkg.sv
// Shared types and constants for the set intersection block.
// No dependencies; used by every module under rtl.
package sid_pkg;

	// List sizing
	localparam int LIST_DEPTH = 32;
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
	localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int VAL_W      = 32;

	// Command codes on the input tuser field
	localparam logic [1:0] CMD_LOAD_A  = 2'd0;
	localparam logic [1:0] CMD_LOAD_B  = 2'd1;
	localparam logic [1:0] CMD_COMPUTE = 2'd2;

	// Classified operation carried through the queue
	typedef enum logic [1:0] {
		OP_LOAD_A  = 2'd0,
		OP_LOAD_B  = 2'd1,
		OP_COMPUTE = 2'd2
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [VAL_W-1:0] value;
	} item_t;

	// Queue handshake between front and back
	typedef struct packed {
		logic  valid;
		item_t item;
	} q_push_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} q_head_t;

endpackage

FILE: rtl/set_intersection_distinct.sv
// Top level of the set intersection block: input stage, queue and back end.
// Depends on sid_pkg, sid_front, sid_fifo and sid_back.
//
// Loads two lists of signed 32-bit values (s_tuser 0 or 1) and on a compute
// word (s_tuser 2) emits each value of the first list that also occurs in the
// second, once, in first-list order; m_tuser[0] is found, m_tuser[1] the
// overflow flag, m_tlast marks the final word, and an empty result gives one
// marker word with found low. Code 3 is accepted and ignored. Appends are
// taken at one word per cycle while no compute or result output is running.
// A compute reads each first-list entry, scans the second list for it and,
// on a match, scans the results so far; its speed is set by the single
// registered read port of each list memory and a separate read state and
// compare state per entry. Words queued behind a compute wait until its
// last result is loaded. No clearing pass after reset.
module set_intersection_distinct import sid_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [VAL_W-1:0] s_tdata,   // value
	input  logic [1:0]       s_tuser,   // cmd
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [VAL_W-1:0] m_tdata,   // value_res
	output logic [1:0]       m_tuser,   // found, overflow
	output logic             m_tlast
);

	q_push_t push;
	q_head_t head;
	logic    push_ready;
	logic    pop;

	sid_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push       (push),
		.push_ready (push_ready)
	);

	sid_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.head       (head),
		.pop        (pop)
	);

	sid_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

FILE: rtl/sid_front.sv
// Input stage: registers each stream word, classifies the command and drops
// unused codes before they reach the queue. Depends on sid_pkg.
module sid_front import sid_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [VAL_W-1:0] s_tdata,   // value
	input  logic [1:0]       s_tuser,   // cmd
	output q_push_t          push,
	input  logic             push_ready
);

	logic  valid_s1;
	logic  keep_s1;
	item_t item_s1;
	logic  advance;
	logic  keep_in;
	op_t   op_in;

	// Decode the command of the incoming word
	always_comb begin
		keep_in = 1'b1;
		op_in   = OP_LOAD_A;
		unique case (s_tuser)
			CMD_LOAD_A:  op_in = OP_LOAD_A;
			CMD_LOAD_B:  op_in = OP_LOAD_B;
			CMD_COMPUTE: op_in = OP_COMPUTE;
			default:     keep_in = 1'b0;
		endcase
	end

	// Stage moves on when its word is pushed or is a dropped code
	assign advance  = valid_s1 && (!keep_s1 || push_ready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			keep_s1       <= keep_in;
			item_s1.op    <= op_in;
			item_s1.value <= s_tdata;
		end
	end

	assign push.valid = valid_s1 && keep_s1;
	assign push.item  = item_s1;

endmodule

FILE: rtl/sid_fifo.sv
// Two-entry queue of classified operations between front and back.
// Depends on sid_pkg.
module sid_fifo import sid_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  q_push_t push,
	output logic    push_ready,
	output q_head_t head,
	input  logic    pop
);

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign do_push    = push.valid && push_ready;
	assign do_pop     = pop && (count_q != 2'd0);

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push.item;
	end

	assign head.valid = (count_q != 2'd0);
	assign head.item  = mem_q[rd_ptr_q];

endmodule

FILE: rtl/sid_back.sv
// Back end: list memories, intersection sequencer and output register.
// Depends on sid_pkg.
module sid_back import sid_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  q_head_t          head,
	output logic             pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [VAL_W-1:0] m_tdata,   // value_res
	output logic [1:0]       m_tuser,   // found, overflow
	output logic             m_tlast
);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_F_RD   = 9'b000000010,
		S_F_LD   = 9'b000000100,
		S_S_RD   = 9'b000001000,
		S_S_CMP  = 9'b000010000,
		S_E_RD   = 9'b000100000,
		S_E_CMP  = 9'b001000000,
		S_OUT_RD = 9'b010000000,
		S_OUT_LD = 9'b100000000
	} state_t;

	state_t state_q;

	logic [VAL_W-1:0] first_mem  [LIST_DEPTH];
	logic [VAL_W-1:0] second_mem [LIST_DEPTH];
	logic [VAL_W-1:0] emit_mem   [LIST_DEPTH];
	logic [VAL_W-1:0] first_rd_q;
	logic [VAL_W-1:0] second_rd_q;
	logic [VAL_W-1:0] emit_rd_q;

	logic [CNT_W-1:0] first_cnt_q;
	logic [CNT_W-1:0] second_cnt_q;
	logic [CNT_W-1:0] emit_cnt_q;
	logic [CNT_W-1:0] i_q;
	logic [CNT_W-1:0] j_q;
	logic [CNT_W-1:0] k_q;
	logic [VAL_W-1:0] cand_q;
	logic             ovf_q;

	logic             out_valid_q;
	logic [VAL_W-1:0] out_value_q;
	logic             out_found_q;
	logic             out_last_q;
	logic             out_ovf_q;

	logic             out_free;
	logic             wr_first;
	logic             wr_second;
	logic             wr_emit;
	logic             first_full;
	logic             second_full;
	logic             emit_empty;
	logic             is_final;

	assign out_free    = !out_valid_q || m_tready;
	assign first_full  = (first_cnt_q == CNT_W'(LIST_DEPTH));
	assign second_full = (second_cnt_q == CNT_W'(LIST_DEPTH));
	assign emit_empty  = (emit_cnt_q == '0);
	assign is_final    = emit_empty || ((k_q + CNT_W'(1)) == emit_cnt_q);

	assign pop       = (state_q == S_IDLE) && head.valid;
	assign wr_first  = pop && (head.item.op == OP_LOAD_A) && !first_full;
	assign wr_second = pop && (head.item.op == OP_LOAD_B) && !second_full;
	assign wr_emit   = (state_q == S_E_RD) && (k_q == emit_cnt_q);

	// Memories: one write and one registered read each, read every cycle
	always_ff @(posedge clk) begin
		if (wr_first)  first_mem[first_cnt_q[IDX_W-1:0]]   <= head.item.value;
		if (wr_second) second_mem[second_cnt_q[IDX_W-1:0]] <= head.item.value;
		if (wr_emit)   emit_mem[emit_cnt_q[IDX_W-1:0]]     <= cand_q;
		first_rd_q  <= first_mem[i_q[IDX_W-1:0]];
		second_rd_q <= second_mem[j_q[IDX_W-1:0]];
		emit_rd_q   <= emit_mem[k_q[IDX_W-1:0]];
	end

	// Sequencer: appends in idle, then scans first x second x emitted, then loads the result words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			first_cnt_q  <= '0;
			second_cnt_q <= '0;
			emit_cnt_q   <= '0;
			i_q          <= '0;
			j_q          <= '0;
			k_q          <= '0;
			ovf_q        <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (head.valid) begin
						unique case (head.item.op)
							OP_LOAD_A: begin
								if (first_full) ovf_q <= 1'b1;
								else first_cnt_q <= first_cnt_q + CNT_W'(1);
							end
							OP_LOAD_B: begin
								if (second_full) ovf_q <= 1'b1;
								else second_cnt_q <= second_cnt_q + CNT_W'(1);
							end
							OP_COMPUTE: begin
								i_q        <= '0;
								emit_cnt_q <= '0;
								state_q    <= S_F_RD;
							end
							default: ;
						endcase
					end
				end
				S_F_RD: begin
					if (i_q == first_cnt_q) begin
						k_q     <= '0;
						state_q <= S_OUT_RD;
					end else begin
						state_q <= S_F_LD;
					end
				end
				S_F_LD: begin
					cand_q  <= first_rd_q;
					j_q     <= '0;
					state_q <= S_S_RD;
				end
				S_S_RD: begin
					if (j_q == second_cnt_q) begin
						i_q     <= i_q + CNT_W'(1);
						state_q <= S_F_RD;
					end else begin
						state_q <= S_S_CMP;
					end
				end
				S_S_CMP: begin
					if (second_rd_q == cand_q) begin
						k_q     <= '0;
						state_q <= S_E_RD;
					end else begin
						j_q     <= j_q + CNT_W'(1);
						state_q <= S_S_RD;
					end
				end
				S_E_RD: begin
					// not yet emitted: store it and move to the next candidate
					if (k_q == emit_cnt_q) begin
						emit_cnt_q <= emit_cnt_q + CNT_W'(1);
						i_q        <= i_q + CNT_W'(1);
						state_q    <= S_F_RD;
					end else begin
						state_q <= S_E_CMP;
					end
				end
				S_E_CMP: begin
					if (emit_rd_q == cand_q) begin
						i_q     <= i_q + CNT_W'(1);
						state_q <= S_F_RD;
					end else begin
						k_q     <= k_q + CNT_W'(1);
						state_q <= S_E_RD;
					end
				end
				S_OUT_RD: begin
					state_q <= S_OUT_LD;
				end
				S_OUT_LD: begin
					if (out_free) begin
						if (is_final) begin
							first_cnt_q  <= '0;
							second_cnt_q <= '0;
							emit_cnt_q   <= '0;
							ovf_q        <= 1'b0;
							state_q      <= S_IDLE;
						end else begin
							k_q     <= k_q + CNT_W'(1);
							state_q <= S_OUT_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output word valid: set on load, cleared once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_OUT_LD) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output word payload; marker word when nothing matched
	always_ff @(posedge clk) begin
		if ((state_q == S_OUT_LD) && out_free) begin
			out_value_q <= emit_empty ? '0 : emit_rd_q;
			out_found_q <= !emit_empty;
			out_last_q  <= is_final;
			out_ovf_q   <= ovf_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_value_q;
	assign m_tuser  = {out_ovf_q, out_found_q};
	assign m_tlast  = out_last_q;

	// Checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(first_cnt_q <= CNT_W'(LIST_DEPTH)) && (second_cnt_q <= CNT_W'(LIST_DEPTH)))
		else $error("list count beyond depth");

	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		emit_cnt_q <= first_cnt_q)
		else $error("more results than first-list entries");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_OUT_LD)
		else $error("output word raised outside the output phase");

	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_found_q) |-> out_last_q)
		else $error("empty marker word not flagged last");

endmodule

FILE: bench/tb_set_intersection_distinct.sv
// Self-checking bench for set_intersection_distinct: list loads, computes, overflow.
// Depends on sid_pkg and the set_intersection_distinct RTL; predicts every result word
// with its own model of both lists and checks it field by field.
module tb_set_intersection_distinct;
	import sid_pkg::*;

	localparam logic [1:0]       CMD_IGNORED  = 2'd3;   // unused code, block drops it
	localparam logic [VAL_W-1:0] VAL_MIN      = 32'h8000_0000;
	localparam logic [VAL_W-1:0] VAL_MAX      = 32'h7fff_ffff;
	localparam int               RANDOM_WORDS = 460;
	localparam int               TAIL_WORDS   = 60;     // no idling for the last words
	localparam int               HOLD_AFTER   = 150;    // input words before the long stall
	localparam int               LONG_HOLD    = 500;
	localparam int               STALL_LIMIT  = 40000;  // well beyond the slowest full compute
	localparam int               END_CYCLES   = 200;

	typedef struct {
		logic [1:0]       cmd;
		logic [VAL_W-1:0] value;
		bit               drain;   // wait for all results before offering this word
	} load_word_t;

	typedef struct {
		logic signed [VAL_W-1:0] value_res;
		logic                    found;
		logic                    last;
		logic                    overflow;
	} hit_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [VAL_W-1:0] s_tdata = '0;    // value
	logic [1:0]       s_tuser = '0;    // cmd
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [VAL_W-1:0] m_tdata;         // value_res
	logic [1:0]       m_tuser;         // found, overflow
	logic             m_tlast;

	load_word_t pending_words[$];
	hit_t       expected_hits[$];
	hit_t       want_hit;

	// predictor state
	logic [VAL_W-1:0] list_a [LIST_DEPTH];
	logic [VAL_W-1:0] list_b [LIST_DEPTH];
	int               count_a = 0;
	int               count_b = 0;
	bit               dropped_append = 1'b0;

	int  outstanding = 0;   // expected words not yet seen, updated once per edge
	int  words_in = 0;
	bit  quiet = 1'b0;
	int  fails = 0;
	int  results_seen = 0;
	int  computes_seen = 0;
	int  overflow_computes = 0;
	int  stalled_cycles = 0;
	int  gap_left = 0;
	int  stall_left = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	int  words_queued = 0;

	set_intersection_distinct DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #1 clk = ~clk;

	// Update the predicted lists for one accepted word; a compute queues its result words and empties both.
	task automatic predict_intersection(input logic [1:0] cmd, input logic [VAL_W-1:0] val);
		logic [VAL_W-1:0] hits[$];
		bit               in_b;
		bit               dup;
		hit_t             h;
		case (cmd)
		CMD_LOAD_A: begin
			if (count_a >= LIST_DEPTH) dropped_append = 1'b1;
			else begin
				list_a[count_a] = val;
				count_a++;
			end
		end
		CMD_LOAD_B: begin
			if (count_b >= LIST_DEPTH) dropped_append = 1'b1;
			else begin
				list_b[count_b] = val;
				count_b++;
			end
		end
		CMD_COMPUTE: begin
			for (int i = 0; i < count_a; i++) begin
				in_b = 1'b0;
				dup  = 1'b0;
				for (int j = 0; j < count_b; j++)
					if (list_b[j] == list_a[i]) in_b = 1'b1;
				foreach (hits[k])
					if (hits[k] == list_a[i]) dup = 1'b1;
				if (in_b && !dup) hits.push_back(list_a[i]);
			end
			h.overflow = dropped_append;
			if (hits.size() == 0) begin
				// empty intersection: a single marker word
				h.value_res = '0;
				h.found     = 1'b0;
				h.last      = 1'b1;
				expected_hits.push_back(h);
			end else begin
				foreach (hits[k]) begin
					h.value_res = hits[k];
					h.found     = 1'b1;
					h.last      = (k == hits.size() - 1);
					expected_hits.push_back(h);
				end
			end
			computes_seen++;
			if (dropped_append) overflow_computes++;
			count_a = 0;
			count_b = 0;
			dropped_append = 1'b0;
		end
		default: ;
		endcase
	endtask

	task automatic queue_word(input logic [1:0] cmd, input logic [VAL_W-1:0] val,
			input bit drain = 1'b0);
		load_word_t w;
		w.cmd   = cmd;
		w.value = val;
		w.drain = drain;
		pending_words.push_back(w);
		words_queued++;
	endtask

	// Sender: offers queued words, with random gaps and drain pauses.
	always @(posedge clk) begin
		load_word_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!(s_tvalid && !s_tready)) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pending_words.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (pending_words[0].drain && (s_tvalid || outstanding != 0)) begin
				s_tvalid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				gap_left = $urandom_range(1, 14) - 1;
				s_tvalid <= 1'b0;
			end else begin
				nxt = pending_words.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= nxt.value;
				s_tuser  <= nxt.cmd;
			end
			quiet <= (pending_words.size() < TAIL_WORDS);
		end
	end

	// Receiver: random stalls, plus one long hold-off while results wait.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (!hold_done && words_in >= HOLD_AFTER && m_tvalid) begin
			hold_done = 1'b1;
			hold_left = LONG_HOLD - 1;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 14) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Monitor: check result words, predict from accepted input words, watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_hits.size() == 0) begin
					$error("unexpected result word: value_res %0d found %0d last %0d",
						$signed(m_tdata), m_tuser[0], m_tlast);
					fails++;
				end else begin
					want_hit = expected_hits.pop_front();
					if (m_tdata !== want_hit.value_res) begin
						$error("value_res: expected %0d, got %0d",
							want_hit.value_res, $signed(m_tdata));
						fails++;
					end
					if (m_tuser[0] !== want_hit.found) begin
						$error("found: expected %0d, got %0d", want_hit.found, m_tuser[0]);
						fails++;
					end
					if (m_tlast !== want_hit.last) begin
						$error("last: expected %0d, got %0d", want_hit.last, m_tlast);
						fails++;
					end
					if (m_tuser[1] !== want_hit.overflow) begin
						$error("overflow: expected %0d, got %0d",
							want_hit.overflow, m_tuser[1]);
						fails++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				predict_intersection(s_tuser, s_tdata);
				words_in <= words_in + 1;
			end
			outstanding <= expected_hits.size();
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stalled_cycles = 0;
			else stalled_cycles++;
			if (stalled_cycles >= STALL_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", STALL_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		logic [VAL_W-1:0] pool [6];
		int               kind;
		int               na;
		int               nb;
		bit               first_job;
		logic [VAL_W-1:0] v;

		// directed: empty compute, extremes, duplicates, ignored code, disjoint lists
		queue_word(CMD_COMPUTE, 32'h1234_5678);
		queue_word(CMD_LOAD_A, VAL_MIN);
		queue_word(CMD_LOAD_A, VAL_MAX);
		queue_word(CMD_LOAD_A, '0);
		queue_word(CMD_LOAD_A, '1);
		queue_word(CMD_LOAD_A, 32'd5);
		queue_word(CMD_LOAD_A, VAL_MAX);
		queue_word(CMD_LOAD_A, VAL_MIN);
		queue_word(CMD_LOAD_B, '1);
		queue_word(CMD_LOAD_B, VAL_MAX);
		queue_word(CMD_IGNORED, 32'hdead_beef);
		queue_word(CMD_LOAD_B, 32'd9);
		queue_word(CMD_LOAD_B, VAL_MIN);
		queue_word(CMD_LOAD_B, VAL_MAX);
		queue_word(CMD_COMPUTE, '0);
		queue_word(CMD_LOAD_A, 32'd3, 1'b1);
		queue_word(CMD_LOAD_B, 32'd4);
		queue_word(CMD_COMPUTE, '1);
		queue_word(CMD_IGNORED, '0);
		queue_word(CMD_LOAD_B, 32'd4);
		queue_word(CMD_COMPUTE, '0);

		// random jobs: mostly short well-formed loads, some full or overfilled lists
		first_job = 1'b1;
		while (words_queued < RANDOM_WORDS) begin
			kind = $urandom_range(0, 19);
			if (kind < 13) begin
				na = $urandom_range(0, 8);
				nb = $urandom_range(0, 8);
			end else if (kind < 16) begin
				na = $urandom_range(9, LIST_DEPTH);
				nb = $urandom_range(9, LIST_DEPTH);
			end else if (kind < 18) begin
				na = $urandom_range(LIST_DEPTH - 1, LIST_DEPTH + 3);
				nb = $urandom_range(0, LIST_DEPTH + 3);
			end else begin
				// lopsided: one list empty or nearly so
				na = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
				nb = (na == 0) ? $urandom_range(0, 4) : 0;
			end
			foreach (pool[k]) begin
				case ($urandom_range(0, 9))
				0: pool[k] = VAL_MIN;
				1: pool[k] = VAL_MAX;
				2: pool[k] = '0;
				3: pool[k] = '1;
				default: pool[k] = $urandom;
				endcase
			end
			if (first_job || $urandom_range(0, 5) == 0) begin
				// the first word of this job waits for all earlier results
				queue_word(CMD_IGNORED, $urandom, 1'b1);
				first_job = 1'b0;
			end
			while (na > 0 || nb > 0) begin
				v = ($urandom_range(0, 3) != 0) ? pool[$urandom_range(0, 5)] : $urandom;
				if (nb == 0 || (na > 0 && $urandom_range(0, 1))) begin
					queue_word(CMD_LOAD_A, v);
					na--;
				end else begin
					queue_word(CMD_LOAD_B, v);
					nb--;
				end
				if ($urandom_range(0, 11) == 0) queue_word(CMD_IGNORED, $urandom);
			end
			// now and then a job runs on into the next without a compute
			if ($urandom_range(0, 9) != 0) queue_word(CMD_COMPUTE, $urandom);
		end
		queue_word(CMD_COMPUTE, $urandom);

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		do @(negedge clk);
		while (pending_words.size() != 0 || s_tvalid || outstanding != 0);
		repeat (END_CYCLES) @(negedge clk);

		if (outstanding != 0) begin
			$error("%0d expected result words never arrived", outstanding);
			fails++;
		end
		$display("Run covered %0d input words and %0d computes (%0d with a dropped append),",
			words_in, computes_seen, overflow_computes);
		$display("checking %0d result words under random gaps and stalls.", results_seen);
		if (fails == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

endmodule

FILE: files.f
rtl/sid_pkg.sv
rtl/sid_front.sv
rtl/sid_fifo.sv
rtl/sid_back.sv
rtl/set_intersection_distinct.sv
bench/tb_set_intersection_distinct.sv
